>>> hw/rtl/mss_pkg.sv
package mss_pkg;

    localparam int MAX_DIM     = 64;
    localparam int VALUE_WIDTH = 8;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int CNT_W       = $clog2(MAX_DIM + 1);
    localparam int ADDR_W      = 2 * DIM_W;
    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int PFX_W       = VALUE_WIDTH + 2 * DIM_W;
    localparam int ACC_W       = PFX_W + 2;
    localparam int SUM_OUT_W   = 19;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_ROW_COUNT = cfg_idx_t'(0);
    localparam cfg_idx_t REG_COL_COUNT = cfg_idx_t'(1);

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [PFX_W-1:0] pfx_t;

    typedef struct packed {
        acc_t a;
        acc_t b;
        logic sub;
    } alu_req_t;

    function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] d;
        if (v == '0)
            d = CNT_W'(1);
        else if (int'(v) > MAX_DIM)
            d = CNT_W'(MAX_DIM);
        else
            d = CNT_W'(v);
        return d;
    endfunction

    function automatic acc_t ext_value(input logic [VALUE_WIDTH-1:0] v);
        return acc_t'({{(ACC_W - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v});
    endfunction

    function automatic acc_t ext_pfx(input pfx_t v);
        return acc_t'({{(ACC_W - PFX_W){v[PFX_W-1]}}, v});
    endfunction

endpackage

>>> hw/rtl/mss_alu.sv
module mss_alu (
    input  mss_pkg::alu_req_t req,
    input  mss_pkg::acc_t     cmp_val,
    output mss_pkg::acc_t     res,
    output logic              gt
);
    import mss_pkg::*;

    assign res = req.sub ? (req.a - req.b) : (req.a + req.b);
    assign gt  = (res > cmp_val);

endmodule

>>> hw/rtl/mss_pmem.sv
module mss_pmem (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [mss_pkg::ADDR_W-1:0]   wr_addr,
    input  mss_pkg::pfx_t                wr_data,
    input  logic [mss_pkg::ADDR_W-1:0]   rd_addr,
    output mss_pkg::pfx_t                rd_data
);
    import mss_pkg::*;

    pfx_t mem_reg [0:DEPTH-1];
    pfx_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/max_sum_submatrix_search.sv
// Channel  Handshake              Fields
// input    in_valid, in_stall     value
// output   out_valid, out_stall   found, best_sum, best_height, best_width, bottom_row, right_col
// config   cfg_we                 cfg_index, cfg_data
//
// Loading takes one prefix-memory read and one write per element.
// The search then runs states SA to SE per rectangle through the single read port of the
// prefix memory, over R*(R+1)/2 * C*(C+1)/2 rectangles for R rows and C columns.
// Reset clears control only; the prefix memory needs no clearing pass.
// A stalled result holds in the output register while the next matrix loads.
module max_sum_submatrix_search (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  mss_pkg::cfg_idx_t                  cfg_index,
    input  logic [mss_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mss_pkg::VALUE_WIDTH-1:0]    value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [mss_pkg::SUM_OUT_W-1:0]      best_sum,
    output logic [mss_pkg::CNT_W-1:0]          best_height,
    output logic [mss_pkg::CNT_W-1:0]          best_width,
    output logic [mss_pkg::DIM_W-1:0]          bottom_row,
    output logic [mss_pkg::DIM_W-1:0]          right_col
);
    import mss_pkg::*;

    typedef enum logic [7:0] {
        ST_LOAD = 8'b0000_0001,
        ST_LWR  = 8'b0000_0010,
        ST_SA   = 8'b0000_0100,
        ST_SB   = 8'b0000_1000,
        ST_SC   = 8'b0001_0000,
        ST_SD   = 8'b0010_0000,
        ST_SE   = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       row_cfg_reg, col_cfg_reg;
    logic [CNT_W-1:0]       rows_eff, cols_eff;

    logic [DIM_W-1:0]       ld_row_reg, ld_row_next;
    logic [DIM_W-1:0]       ld_col_reg, ld_col_next;
    acc_t                   rowacc_reg, rowacc_next;
    acc_t                   acc_reg, acc_next;
    logic                   zero_reg, zero_next;

    logic [CNT_W-1:0]       h_reg, h_next, w_reg, w_next;
    logic [DIM_W-1:0]       x_reg, x_next, y_reg, y_next;

    pfx_t                   best_reg, best_next;
    logic [CNT_W-1:0]       bh_reg, bh_next, bw_reg, bw_next;
    logic [DIM_W-1:0]       brow_reg, brow_next, bcol_reg, bcol_next;

    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [SUM_OUT_W-1:0]   out_sum_reg;
    logic [CNT_W-1:0]       out_h_reg, out_w_reg;
    logic [DIM_W-1:0]       out_row_reg, out_col_reg;

    logic                   pm_wr_en;
    logic [ADDR_W-1:0]      pm_wr_addr, pm_rd_addr;
    pfx_t                   pm_wr_data, pm_rd_data;

    alu_req_t               alu_req;
    acc_t                   alu_res;
    logic                   alu_gt;

    logic                   in_xfer, out_free, cfg_hit;
    logic [CNT_W-1:0]       bot, rgt;
    logic [DIM_W-1:0]       bot_idx, rgt_idx, top_idx, left_idx, ld_above_row;
    logic                   last_col, last_row;
    acc_t                   opnd;

    assign rows_eff = eff_dim(row_cfg_reg);
    assign cols_eff = eff_dim(col_cfg_reg);

    assign in_stall = (state_reg != ST_LOAD);
    assign in_xfer  = in_valid && (state_reg == ST_LOAD);
    assign out_free = !out_valid_reg || !out_stall;
    assign cfg_hit  = cfg_we && ((cfg_index == REG_ROW_COUNT) || (cfg_index == REG_COL_COUNT));

    assign bot          = CNT_W'(x_reg) + h_reg;
    assign rgt          = CNT_W'(y_reg) + w_reg;
    assign bot_idx      = DIM_W'(bot - CNT_W'(1));
    assign rgt_idx      = DIM_W'(rgt - CNT_W'(1));
    assign top_idx      = x_reg - DIM_W'(1);
    assign left_idx     = y_reg - DIM_W'(1);
    assign ld_above_row = ld_row_reg - DIM_W'(1);
    assign last_col     = (CNT_W'(ld_col_reg) == (cols_eff - CNT_W'(1)));
    assign last_row     = (CNT_W'(ld_row_reg) == (rows_eff - CNT_W'(1)));
    assign opnd         = zero_reg ? acc_t'(0) : ext_pfx(pm_rd_data);

    mss_alu u_alu (
        .req     (alu_req),
        .cmp_val (ext_pfx(best_reg)),
        .res     (alu_res),
        .gt      (alu_gt)
    );

    mss_pmem u_pmem (
        .clk     (clk),
        .wr_en   (pm_wr_en),
        .wr_addr (pm_wr_addr),
        .wr_data (pm_wr_data),
        .rd_addr (pm_rd_addr),
        .rd_data (pm_rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        ld_row_next = ld_row_reg;
        ld_col_next = ld_col_reg;
        rowacc_next = rowacc_reg;
        acc_next    = acc_reg;
        h_next      = h_reg;
        w_next      = w_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        best_next   = best_reg;
        bh_next     = bh_reg;
        bw_next     = bw_reg;
        brow_next   = brow_reg;
        bcol_next   = bcol_reg;
        pm_wr_en    = 1'b0;
        pm_wr_addr  = {ld_row_reg, ld_col_reg};
        pm_wr_data  = PFX_W'(alu_res);
        pm_rd_addr  = {ld_above_row, ld_col_reg};
        zero_next   = (ld_row_reg == '0);
        alu_req.a   = acc_reg;
        alu_req.b   = opnd;
        alu_req.sub = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                alu_req.a = (ld_col_reg == '0) ? acc_t'(0) : rowacc_reg;
                alu_req.b = ext_value(value);
                if (in_xfer)
                begin
                    rowacc_next = alu_res;
                    state_next  = ST_LWR;
                end
            end
            ST_LWR:
            begin
                alu_req.a = rowacc_reg;
                pm_wr_en  = 1'b1;
                state_next = ST_LOAD;
                if (last_col)
                begin
                    ld_col_next = '0;
                    if (last_row)
                    begin
                        ld_row_next = '0;
                        h_next      = CNT_W'(1);
                        w_next      = CNT_W'(1);
                        x_next      = '0;
                        y_next      = '0;
                        best_next   = '0;
                        bh_next     = '0;
                        bw_next     = '0;
                        brow_next   = '0;
                        bcol_next   = '0;
                        state_next  = ST_SA;
                    end
                    else
                    begin
                        ld_row_next = ld_row_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    ld_col_next = ld_col_reg + DIM_W'(1);
                end
            end
            ST_SA:
            begin
                pm_rd_addr = {bot_idx, rgt_idx};
                zero_next  = 1'b0;
                state_next = ST_SB;
            end
            ST_SB:
            begin
                alu_req.a  = acc_t'(0);
                acc_next   = alu_res;
                pm_rd_addr = {top_idx, rgt_idx};
                zero_next  = (x_reg == '0);
                state_next = ST_SC;
            end
            ST_SC:
            begin
                alu_req.sub = 1'b1;
                acc_next    = alu_res;
                pm_rd_addr  = {bot_idx, left_idx};
                zero_next   = (y_reg == '0);
                state_next  = ST_SD;
            end
            ST_SD:
            begin
                alu_req.sub = 1'b1;
                acc_next    = alu_res;
                pm_rd_addr  = {top_idx, left_idx};
                zero_next   = (x_reg == '0) || (y_reg == '0);
                state_next  = ST_SE;
            end
            ST_SE:
            begin
                if (alu_gt)
                begin
                    best_next = PFX_W'(alu_res);
                    bh_next   = h_reg;
                    bw_next   = w_reg;
                    brow_next = bot_idx;
                    bcol_next = rgt_idx;
                end
                state_next = ST_SA;
                if (rgt < cols_eff)
                begin
                    y_next = y_reg + DIM_W'(1);
                end
                else
                begin
                    y_next = '0;
                    if (bot < rows_eff)
                    begin
                        x_next = x_reg + DIM_W'(1);
                    end
                    else
                    begin
                        x_next = '0;
                        if (w_reg < cols_eff)
                        begin
                            w_next = w_reg + CNT_W'(1);
                        end
                        else
                        begin
                            w_next = CNT_W'(1);
                            if (h_reg < rows_eff)
                                h_next = h_reg + CNT_W'(1);
                            else
                                state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // restart the load on a write to the row-count or column-count register
        if (cfg_hit)
        begin
            ld_row_next = '0;
            ld_col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            row_cfg_reg   <= CFG_W'(MAX_DIM);
            col_cfg_reg   <= CFG_W'(MAX_DIM);
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ld_row_reg <= ld_row_next;
            ld_col_reg <= ld_col_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_COUNT: row_cfg_reg <= cfg_data;
                    REG_COL_COUNT: col_cfg_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rowacc_reg <= rowacc_next;
        acc_reg    <= acc_next;
        zero_reg   <= zero_next;
        h_reg      <= h_next;
        w_reg      <= w_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        best_reg   <= best_next;
        bh_reg     <= bh_next;
        bw_reg     <= bw_next;
        brow_reg   <= brow_next;
        bcol_reg   <= bcol_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_found_reg <= (best_reg != '0);
            out_sum_reg   <= best_reg[SUM_OUT_W-1:0];
            out_h_reg     <= bh_reg;
            out_w_reg     <= bw_reg;
            out_row_reg   <= brow_reg;
            out_col_reg   <= bcol_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign best_sum    = out_sum_reg;
    assign best_height = out_h_reg;
    assign best_width  = out_w_reg;
    assign bottom_row  = out_row_reg;
    assign right_col   = out_col_reg;

endmodule
